/* design/pscw_pkg.sv */
// Shared types and constants for the windowed-integral PID speed controller.
// No dependencies; used by pscw_smac, pscw_hist and the top level.
package pscw_pkg;

	localparam int GAIN_W  = 24;
	localparam int CNT_W   = 5;
	localparam int QBITS   = 16;
	localparam int ERR_W   = 17;
	localparam int DERIV_W = 18;
	localparam int MEAS_W  = 16;
	localparam int DRIVE_W = 32;
	localparam int DUTY_W  = 10;
	localparam int CFG_W   = 2;

	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GAIN_W - 1);

	localparam logic signed [ERR_W-1:0]   ENC_RELOAD = 17'sd20000;
	localparam logic signed [MEAS_W-1:0]  MEAS_MAX   = 16'sh7fff;
	localparam logic signed [MEAS_W-1:0]  MEAS_MIN   = 16'sh8000;
	localparam logic signed [DRIVE_W-1:0] DRIVE_MAX  = 32'sh7fffffff;
	localparam logic signed [DRIVE_W-1:0] DRIVE_MIN  = 32'sh80000000;
	localparam logic signed [DRIVE_W-1:0] DUTY_LIM   = 32'sd1000;
	localparam logic [DUTY_W-1:0]         DUTY_MAX   = 10'd1000;

	localparam logic [CFG_W-1:0] CFG_PROP_GAIN   = 2'd0;
	localparam logic [CFG_W-1:0] CFG_INTEG_GAIN  = 2'd1;
	localparam logic [CFG_W-1:0] CFG_DERIV_GAIN  = 2'd2;
	localparam logic [CFG_W-1:0] CFG_SPEED_SCALE = 2'd3;

	localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = 24'd524288;
	localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = 24'd655;
	localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = 24'd65536;
	localparam logic [GAIN_W-1:0] SPEED_SCALE_RST = 24'd65536;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MEAS,
		S_ERR,
		S_PID,
		S_DONE
	} state_t;

endpackage

/* design/pscw_smac.sv */
// Bit-serial multiply-accumulate: three signed operands times three unsigned
// Q16 gains, one gain bit per cycle, product shifted out LSB first.
// Depends on pscw_pkg.
module pscw_smac #(
	parameter int OP_W = 22,
	parameter int HI_W = 28
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [OP_W-1:0]                a0,
	input  logic signed [OP_W-1:0]                a1,
	input  logic signed [OP_W-1:0]                a2,
	input  logic [pscw_pkg::GAIN_W-1:0]           g0,
	input  logic [pscw_pkg::GAIN_W-1:0]           g1,
	input  logic [pscw_pkg::GAIN_W-1:0]           g2,
	output logic                                  done,
	output logic signed [HI_W+pscw_pkg::GAIN_W-1:0] prod
);

	logic signed [OP_W-1:0]         a0_q, a1_q, a2_q;
	logic [pscw_pkg::GAIN_W-1:0]    g0_q, g1_q, g2_q;
	logic signed [HI_W-1:0]         hi_q;
	logic [pscw_pkg::GAIN_W-1:0]    lo_q;
	logic [pscw_pkg::CNT_W-1:0]     cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic signed [HI_W-1:0]         addend;
	logic signed [HI_W-1:0]         sum;

	always_comb begin
		addend = '0;
		if (g0_q[0]) addend = addend + HI_W'(a0_q);
		if (g1_q[0]) addend = addend + HI_W'(a1_q);
		if (g2_q[0]) addend = addend + HI_W'(a2_q);
		sum = hi_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == pscw_pkg::LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: add the selected operands to the high half, shift right by one
	always_ff @(posedge clk) begin
		if (start) begin
			a0_q <= a0;
			a1_q <= a1;
			a2_q <= a2;
			g0_q <= g0;
			g1_q <= g1;
			g2_q <= g2;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			g0_q <= g0_q >> 1;
			g1_q <= g1_q >> 1;
			g2_q <= g2_q >> 1;
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[pscw_pkg::GAIN_W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

/* design/pscw_hist.sv */
// Error history window: circular store with a write pointer and fill flag.
// Returns the oldest entry (zero until the window has filled once).
// Depends on pscw_pkg.
module pscw_hist #(
	parameter int DEPTH = 20
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic signed [pscw_pkg::ERR_W-1:0] wr_data,
	output logic signed [pscw_pkg::ERR_W-1:0] oldest
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic signed [pscw_pkg::ERR_W-1:0] mem [DEPTH];
	logic signed [pscw_pkg::ERR_W-1:0] rd_q;
	logic [PTR_W-1:0]                  ptr_q;
	logic                              full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			full_q <= 1'b0;
		end else if (wr_en) begin
			if (ptr_q == PTR_LAST) begin
				ptr_q  <= '0;
				full_q <= 1'b1;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[ptr_q] <= wr_data;
		end
		rd_q <= mem[ptr_q];
	end

	// entry at the pointer holds a written value only once the window has wrapped
	assign oldest = full_q ? rd_q : '0;

endmodule

/* design/pid_speed_control_windowed_integral.sv */
// PID speed controller with windowed integral, one control tick per item.
// A new item is taken only once the previous result has reached the output register;
// each item makes two 24-step passes through the shared bit-serial MAC.
// A finished result waits in the output register while the next item runs.
// Reset (arst_n low, asynchronous): gains to defaults, history window empty,
// integral sum and previous error cleared, no result pending.
module pid_speed_control_windowed_integral #(
	parameter int WINDOW = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic signed [15:0]                  target_speed,
	input  logic [15:0]                         encoder_count,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [pscw_pkg::DUTY_W-1:0]         duty,
	output logic                                forward,
	output logic signed [pscw_pkg::DRIVE_W-1:0] drive_value,
	output logic signed [pscw_pkg::MEAS_W-1:0]  measured_speed,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pscw_pkg::CFG_W-1:0]          cfg_index,
	input  logic [23:0]                         cfg_data
);

	localparam int SUM_W  = pscw_pkg::ERR_W + $clog2(WINDOW);
	localparam int HI_W   = SUM_W + 6;
	localparam int PROD_W = HI_W + pscw_pkg::GAIN_W;
	localparam int TRIM_W = PROD_W - pscw_pkg::QBITS;

	pscw_pkg::state_t state_q, state_d;

	logic [pscw_pkg::GAIN_W-1:0] prop_gain_q, integ_gain_q, deriv_gain_q, speed_scale_q;

	logic signed [15:0]                   target_q;
	logic signed [pscw_pkg::MEAS_W-1:0]   meas_q;
	logic signed [pscw_pkg::ERR_W-1:0]    prev_q;
	logic signed [SUM_W-1:0]              sum_q;
	logic signed [pscw_pkg::DRIVE_W-1:0]  drive_q;

	logic                                 rsp_valid_q;
	logic [pscw_pkg::DUTY_W-1:0]          duty_q;
	logic                                 forward_q;
	logic signed [pscw_pkg::DRIVE_W-1:0]  drive_out_q;
	logic signed [pscw_pkg::MEAS_W-1:0]   meas_out_q;

	logic                                 accept;
	logic                                 mac_start;
	logic                                 mac_done;
	logic signed [SUM_W-1:0]              mac_a0, mac_a1, mac_a2;
	logic [pscw_pkg::GAIN_W-1:0]          mac_g0, mac_g1, mac_g2;
	logic signed [PROD_W-1:0]             prod;
	logic signed [TRIM_W-1:0]             trim;
	logic                                 meas_fits, drive_fits;
	logic signed [pscw_pkg::MEAS_W-1:0]   meas_sat;
	logic signed [pscw_pkg::DRIVE_W-1:0]  drive_sat;

	logic signed [pscw_pkg::ERR_W-1:0]    distance;
	logic signed [pscw_pkg::ERR_W-1:0]    err;
	logic signed [pscw_pkg::DERIV_W-1:0]  deriv;
	logic signed [SUM_W-1:0]              sum_new;
	logic signed [pscw_pkg::ERR_W-1:0]    oldest;
	logic                                 hist_we;
	logic                                 load_meas, load_drive, load_out;

	logic                                 duty_big;
	logic signed [10:0]                   drive_lo;
	logic [10:0]                          drive_abs;
	logic [pscw_pkg::DUTY_W-1:0]          duty_calc;

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q   <= pscw_pkg::PROP_GAIN_RST;
			integ_gain_q  <= pscw_pkg::INTEG_GAIN_RST;
			deriv_gain_q  <= pscw_pkg::DERIV_GAIN_RST;
			speed_scale_q <= pscw_pkg::SPEED_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pscw_pkg::CFG_PROP_GAIN:   prop_gain_q   <= cfg_data;
				pscw_pkg::CFG_INTEG_GAIN:  integ_gain_q  <= cfg_data;
				pscw_pkg::CFG_DERIV_GAIN:  deriv_gain_q  <= cfg_data;
				pscw_pkg::CFG_SPEED_SCALE: speed_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- datapath ----------------
	assign accept   = req_valid && !req_stall;
	assign distance = pscw_pkg::ERR_W'(signed'({1'b0, encoder_count})) - pscw_pkg::ENC_RELOAD;
	assign err      = pscw_pkg::ERR_W'(target_q) - pscw_pkg::ERR_W'(meas_q);
	assign deriv    = pscw_pkg::DERIV_W'(err) - pscw_pkg::DERIV_W'(prev_q);
	assign sum_new  = sum_q + SUM_W'(err) - SUM_W'(oldest);

	// first pass scales the encoder distance, second pass forms the PID sum
	always_comb begin
		if (state_q == pscw_pkg::S_IDLE) begin
			mac_a0 = SUM_W'(distance);
			mac_a1 = '0;
			mac_a2 = '0;
			mac_g0 = speed_scale_q;
			mac_g1 = '0;
			mac_g2 = '0;
		end else begin
			mac_a0 = SUM_W'(err);
			mac_a1 = sum_new;
			mac_a2 = SUM_W'(deriv);
			mac_g0 = prop_gain_q;
			mac_g1 = integ_gain_q;
			mac_g2 = deriv_gain_q;
		end
	end

	pscw_smac #(
		.OP_W (SUM_W),
		.HI_W (HI_W)
	) u_smac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.a0     (mac_a0),
		.a1     (mac_a1),
		.a2     (mac_a2),
		.g0     (mac_g0),
		.g1     (mac_g1),
		.g2     (mac_g2),
		.done   (mac_done),
		.prod   (prod)
	);

	pscw_hist #(
		.DEPTH (WINDOW)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (hist_we),
		.wr_data (err),
		.oldest  (oldest)
	);

	// floor by 2^16 is dropping the low bits; saturate by checking the sign run
	assign trim       = prod[PROD_W-1:pscw_pkg::QBITS];
	assign meas_fits  = (&trim[TRIM_W-1:pscw_pkg::MEAS_W-1]) |
	                    ~(|trim[TRIM_W-1:pscw_pkg::MEAS_W-1]);
	assign drive_fits = (&trim[TRIM_W-1:pscw_pkg::DRIVE_W-1]) |
	                    ~(|trim[TRIM_W-1:pscw_pkg::DRIVE_W-1]);
	assign meas_sat   = meas_fits ? trim[pscw_pkg::MEAS_W-1:0] :
	                    (trim[TRIM_W-1] ? pscw_pkg::MEAS_MIN : pscw_pkg::MEAS_MAX);
	assign drive_sat  = drive_fits ? trim[pscw_pkg::DRIVE_W-1:0] :
	                    (trim[TRIM_W-1] ? pscw_pkg::DRIVE_MIN : pscw_pkg::DRIVE_MAX);

	// within +-1000 only the low 11 bits matter for the magnitude
	assign duty_big  = (drive_q > pscw_pkg::DUTY_LIM) || (drive_q < -pscw_pkg::DUTY_LIM);
	assign drive_lo  = drive_q[10:0];
	assign drive_abs = drive_lo[10] ? 11'(-drive_lo) : 11'(drive_lo);
	assign duty_calc = duty_big ? pscw_pkg::DUTY_MAX : drive_abs[pscw_pkg::DUTY_W-1:0];

	// ---------------- control ----------------
	always_comb begin
		state_d    = state_q;
		req_stall  = 1'b1;
		mac_start  = 1'b0;
		hist_we    = 1'b0;
		load_meas  = 1'b0;
		load_drive = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			pscw_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					mac_start = 1'b1;
					state_d   = pscw_pkg::S_MEAS;
				end
			end
			pscw_pkg::S_MEAS: begin
				if (mac_done) begin
					load_meas = 1'b1;
					state_d   = pscw_pkg::S_ERR;
				end
			end
			pscw_pkg::S_ERR: begin
				mac_start = 1'b1;
				hist_we   = 1'b1;
				state_d   = pscw_pkg::S_PID;
			end
			pscw_pkg::S_PID: begin
				if (mac_done) begin
					load_drive = 1'b1;
					state_d    = pscw_pkg::S_DONE;
				end
			end
			pscw_pkg::S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					load_out = 1'b1;
					state_d  = pscw_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pscw_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pscw_pkg::S_IDLE;
			rsp_valid_q <= 1'b0;
			sum_q       <= '0;
			prev_q      <= '0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (hist_we) begin
				sum_q  <= sum_new;
				prev_q <= err;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			target_q <= target_speed;
		end
		if (load_meas) begin
			meas_q <= meas_sat;
		end
		if (load_drive) begin
			drive_q <= drive_sat;
		end
		if (load_out) begin
			duty_q      <= duty_calc;
			forward_q   <= !drive_q[pscw_pkg::DRIVE_W-1] && (drive_q != '0);
			drive_out_q <= drive_q;
			meas_out_q  <= meas_q;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign duty           = duty_q;
	assign forward        = forward_q;
	assign drive_value    = drive_out_q;
	assign measured_speed = meas_out_q;

`ifndef SYNTHESIS
	a_mac_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> (state_q == pscw_pkg::S_MEAS || state_q == pscw_pkg::S_PID))
		else $error("MAC finished outside a multiply state");

	a_rsp_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == pscw_pkg::S_DONE)
		else $error("result posted without a finished item");

	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> duty <= pscw_pkg::DUTY_MAX)
		else $error("duty above limit");

	a_forward_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && forward) |-> (!drive_value[pscw_pkg::DRIVE_W-1] && drive_value != '0))
		else $error("forward set with non-positive drive");
`endif

endmodule

/* tb/pid_speed_control_windowed_integral_tb.sv */
// Self-checking testbench for the windowed-integral PID speed controller.
// Directed rows, then randomized gain settings and control ticks with random
// request gaps and result stalls; needs pscw_pkg and pid_speed_control_windowed_integral.
module pid_speed_control_windowed_integral_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW       = 20;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int HOLD_CYCLES  = 600;
	localparam int TAIL_CYCLES  = 60;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_TICKS  = 190;
	localparam int N_ROWS       = 23;

	localparam logic [pscw_pkg::CFG_W-1:0] REG_INDEX [4] = '{
		pscw_pkg::CFG_PROP_GAIN, pscw_pkg::CFG_INTEG_GAIN, pscw_pkg::CFG_DERIV_GAIN,
		pscw_pkg::CFG_SPEED_SCALE
	};

	typedef struct packed {
		logic signed [15:0] target;
		logic [15:0]        count;
	} tick_t;

	typedef struct packed {
		logic [pscw_pkg::DUTY_W-1:0]         duty;
		logic                                forward;
		logic signed [pscw_pkg::DRIVE_W-1:0] drive;
		logic signed [pscw_pkg::MEAS_W-1:0]  speed;
	} ctrl_out_t;

	typedef struct packed {
		logic [1:0] setting;
		tick_t      tick;
		logic       typed;
		ctrl_out_t  want;
	} row_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                req_valid = 1'b0;
	logic                                req_stall;
	logic signed [15:0]                  target_speed = '0;
	logic [15:0]                         encoder_count = '0;
	logic                                rsp_valid;
	logic                                rsp_stall = 1'b0;
	logic [pscw_pkg::DUTY_W-1:0]         duty;
	logic                                forward;
	logic signed [pscw_pkg::DRIVE_W-1:0] drive_value;
	logic signed [pscw_pkg::MEAS_W-1:0]  measured_speed;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [pscw_pkg::CFG_W-1:0]          cfg_index = '0;
	logic [23:0]                         cfg_data = '0;

	// controller image: gains and error window
	logic [pscw_pkg::GAIN_W-1:0]       kp = pscw_pkg::PROP_GAIN_RST;
	logic [pscw_pkg::GAIN_W-1:0]       ki = pscw_pkg::INTEG_GAIN_RST;
	logic [pscw_pkg::GAIN_W-1:0]       kd = pscw_pkg::DERIV_GAIN_RST;
	logic [pscw_pkg::GAIN_W-1:0]       scale = pscw_pkg::SPEED_SCALE_RST;
	logic signed [pscw_pkg::ERR_W-1:0] err_hist [WINDOW];
	longint                            err_total;
	int                                hist_ptr;

	ctrl_out_t pending_outputs [$];
	int        fault_count = 0;
	int        cycles = 0;
	int        track = 0;
	bit        quiet = 1'b0;
	bit        hold_req = 1'b0;
	bit        offering = 1'b0;

	pid_speed_control_windowed_integral #(.WINDOW(WINDOW)) u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.target_speed   (target_speed),
		.encoder_count  (encoder_count),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.duty           (duty),
		.forward        (forward),
		.drive_value    (drive_value),
		.measured_speed (measured_speed),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [pscw_pkg::GAIN_W-1:0] pick_gain(
		input logic [pscw_pkg::GAIN_W-1:0] dflt);
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return '0;
			1: return '1;
			2, 3, 4: return dflt;
			5, 6, 7: return pscw_pkg::GAIN_W'($urandom_range(0, 1 << 17));
			default: return pscw_pkg::GAIN_W'($urandom);
		endcase
	endfunction

	// One control tick: measured speed, error window update, PID drive, duty.
	function automatic ctrl_out_t compute_control_tick(input tick_t t);
		longint travel, meas, err, prev, dv, acc, drv, mag;
		ctrl_out_t r;
		travel = longint'(t.count) - longint'(pscw_pkg::ENC_RELOAD);
		meas = (travel * longint'(scale)) >>> pscw_pkg::QBITS;
		if (meas > longint'(pscw_pkg::MEAS_MAX))
			meas = longint'(pscw_pkg::MEAS_MAX);
		if (meas < longint'(pscw_pkg::MEAS_MIN))
			meas = longint'(pscw_pkg::MEAS_MIN);
		err = longint'(t.target) - meas;
		prev = longint'(err_hist[(hist_ptr + WINDOW - 1) % WINDOW]);
		err_total = err_total + err - longint'(err_hist[hist_ptr]);
		err_hist[hist_ptr] = pscw_pkg::ERR_W'(err);
		hist_ptr = (hist_ptr + 1) % WINDOW;
		dv = err - prev;
		acc = longint'(kp) * err + longint'(ki) * err_total + longint'(kd) * dv;
		drv = acc >>> pscw_pkg::QBITS;
		if (drv > longint'(pscw_pkg::DRIVE_MAX))
			drv = longint'(pscw_pkg::DRIVE_MAX);
		if (drv < longint'(pscw_pkg::DRIVE_MIN))
			drv = longint'(pscw_pkg::DRIVE_MIN);
		mag = (drv < 0) ? -drv : drv;
		if (mag > longint'(pscw_pkg::DUTY_LIM))
			mag = longint'(pscw_pkg::DUTY_LIM);
		r.duty = pscw_pkg::DUTY_W'(mag);
		r.forward = (drv > 0);
		r.drive = pscw_pkg::DRIVE_W'(drv);
		r.speed = pscw_pkg::MEAS_W'(meas);
		return r;
	endfunction

	// Mostly a target that wanders and an encoder that follows it, some noise.
	function automatic tick_t next_tick();
		tick_t t;
		int r;
		longint c;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			track = track + int'($urandom_range(0, 400)) - 200;
			if (track > 30000)
				track = 30000;
			if (track < -20000)
				track = -20000;
			if (scale == 0)
				c = longint'(pscw_pkg::ENC_RELOAD) + track;
			else
				c = longint'(pscw_pkg::ENC_RELOAD) +
					(longint'(track) * 65536) / longint'(scale);
			c = c + int'($urandom_range(0, 100)) - 50;
			if (c < 0)
				c = 0;
			if (c > 65535)
				c = 65535;
			t.target = 16'(track);
			t.count = 16'(c);
		end else if (r < 85) begin
			t.target = 16'($urandom);
			t.count = 16'(longint'(pscw_pkg::ENC_RELOAD) +
				int'($urandom_range(0, 600)) - 300);
		end else begin
			t.target = 16'($urandom);
			t.count = 16'($urandom);
		end
		return t;
	endfunction

	task automatic send_tick(input tick_t t, input logic typed, input ctrl_out_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			if (offering)
				req_valid <= 1'b0;
			offering = 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		target_speed <= t.target;
		encoder_count <= t.count;
		offering = 1'b1;
		do @(posedge clk); while (req_stall);
		want = typed ? want : compute_control_tick(t);
		if (typed)
			void'(compute_control_tick(t));
		pending_outputs.push_back(want);
	endtask

	task automatic end_burst();
		if (offering)
			req_valid <= 1'b0;
		offering = 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_settings(input logic [pscw_pkg::GAIN_W-1:0] vals [4]);
		int order [4];
		int j, tmp;
		order = '{0, 1, 2, 3};
		for (int i = 3; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		foreach (order[k]) begin
			cfg_valid <= 1'b1;
			cfg_index <= REG_INDEX[order[k]];
			cfg_data <= vals[order[k]];
			do @(posedge clk); while (!cfg_ready);
			case (REG_INDEX[order[k]])
				pscw_pkg::CFG_PROP_GAIN:   kp = vals[order[k]];
				pscw_pkg::CFG_INTEG_GAIN:  ki = vals[order[k]];
				pscw_pkg::CFG_DERIV_GAIN:  kd = vals[order[k]];
				pscw_pkg::CFG_SPEED_SCALE: scale = vals[order[k]];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// result side: random stalls, one long hold-off when asked
	initial begin : result_side
		int n;
		forever begin
			if (hold_req) begin
				n = HOLD_CYCLES;
				hold_req = 1'b0;
			end else begin
				n = pick_gap();
			end
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		ctrl_out_t want;
		if (rsp_valid && !rsp_stall) begin
			if (pending_outputs.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("unexpected item: duty %0d forward %0b drive %0d speed %0d",
						duty, forward, drive_value, measured_speed);
			end else begin
				want = pending_outputs.pop_front();
				if (duty !== want.duty || forward !== want.forward ||
						drive_value !== want.drive || measured_speed !== want.speed) begin
					fault_count++;
					if (fault_count <= 10)
						$display({"mismatch (exp/got): duty %0d/%0d forward %0b/%0b",
							" drive %0d/%0d speed %0d/%0d"},
							want.duty, duty, want.forward, forward,
							want.drive, drive_value, want.speed, measured_speed);
				end
			end
		end
	end

	initial begin : stimulus
		row_t plan [N_ROWS];
		logic [pscw_pkg::GAIN_W-1:0] preset [4][4];
		logic [pscw_pkg::GAIN_W-1:0] vals [4];
		int cur_set;

		// presets: reset values, everything full scale, everything zero,
		// and unity proportional only (drive equals the error)
		preset = '{
			'{pscw_pkg::PROP_GAIN_RST, pscw_pkg::INTEG_GAIN_RST, pscw_pkg::DERIV_GAIN_RST,
				pscw_pkg::SPEED_SCALE_RST},
			'{24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff},
			'{24'd0, 24'd0, 24'd0, 24'd0},
			'{24'd65536, 24'd0, 24'd0, 24'd65536}
		};
		plan = '{
			'{2'd0, '{16'sd0, 16'd20000}, 1'b1, '{10'd0, 1'b0, 32'sd0, 16'sd0}},
			'{2'd0, '{16'sd1, 16'd20000}, 1'b1, '{10'd9, 1'b1, 32'sd9, 16'sd0}},
			'{2'd0, '{16'sh7fff, 16'd0}, 1'b0, '0},
			'{2'd0, '{16'sh8000, 16'hffff}, 1'b0, '0},
			'{2'd0, '{16'sh8000, 16'd0}, 1'b0, '0},
			'{2'd0, '{16'sh7fff, 16'hffff}, 1'b0, '0},
			'{2'd0, '{16'sd0, 16'd19999}, 1'b0, '0},
			'{2'd0, '{16'sd0, 16'd20001}, 1'b0, '0},
			'{2'd0, '{16'sd12345, 16'h8000}, 1'b0, '0},
			'{2'd0, '{16'shaaaa, 16'h5555}, 1'b0, '0},
			'{2'd0, '{16'sh5555, 16'haaaa}, 1'b0, '0},
			'{2'd1, '{16'sh7fff, 16'd0}, 1'b0, '0},
			'{2'd1, '{16'sh8000, 16'hffff}, 1'b0, '0},
			'{2'd1, '{16'sd0, 16'd20000}, 1'b0, '0},
			'{2'd1, '{16'sd0, 16'd20001}, 1'b0, '0},
			'{2'd2, '{16'sh7fff, 16'hffff}, 1'b1, '{10'd0, 1'b0, 32'sd0, 16'sd0}},
			'{2'd2, '{16'sh8000, 16'd0}, 1'b1, '{10'd0, 1'b0, 32'sd0, 16'sd0}},
			'{2'd2, '{16'sd100, 16'd20000}, 1'b1, '{10'd0, 1'b0, 32'sd0, 16'sd0}},
			'{2'd3, '{16'sd5, 16'd20000}, 1'b1, '{10'd5, 1'b1, 32'sd5, 16'sd0}},
			'{2'd3, '{-16'sd7, 16'd20000}, 1'b1, '{10'd7, 1'b0, -32'sd7, 16'sd0}},
			'{2'd3, '{16'sd0, 16'd21000}, 1'b1,
				'{10'd1000, 1'b0, -32'sd1000, 16'sd1000}},
			'{2'd3, '{16'sd1001, 16'd20000}, 1'b1,
				'{10'd1000, 1'b1, 32'sd1001, 16'sd0}},
			'{2'd3, '{16'sh8000, 16'hffff}, 1'b1,
				'{10'd1000, 1'b0, -32'sd65535, 16'sh7fff}}
		};
		foreach (err_hist[i])
			err_hist[i] = '0;
		err_total = 0;
		hist_ptr = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cur_set = 0;
		for (int i = 0; i < N_ROWS; i++) begin
			if (plan[i].setting != cur_set) begin
				end_burst();
				cur_set = plan[i].setting;
				write_settings(preset[cur_set]);
			end
			send_tick(plan[i].tick, plan[i].typed, plan[i].want);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			end_burst();
			vals = '{pick_gain(pscw_pkg::PROP_GAIN_RST), pick_gain(pscw_pkg::INTEG_GAIN_RST),
				pick_gain(pscw_pkg::DERIV_GAIN_RST), pick_gain(pscw_pkg::SPEED_SCALE_RST)};
			write_settings(vals);
			for (int n = 0; n < PHASE_TICKS; n++) begin
				// long output hold-off while items keep coming back to back
				if (ph == 1 && n == 40)
					hold_req = 1'b1;
				quiet = (ph == 1 && n >= 40 && n < 80) || (n >= 120 && n < 150);
				send_tick(next_tick(), 1'b0, '0);
			end
		end
		quiet = 1'b0;
		end_burst();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
